>>> design/oclt_pkg.sv
// Shared types, constants and ring helpers for the ordered configuration log table.
`default_nettype none

package oclt_pkg;

	// Table depth and derived widths
	localparam int CAPACITY = 64;
	localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = 63;
	localparam int TERM_W   = 32;
	localparam int HDL_W    = 32;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CNT_W:0]    sum_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [TERM_W-1:0] term_t;
	typedef logic [HDL_W-1:0]  hdl_t;

	typedef struct packed {
		idx_t  idx;
		term_t term;
		hdl_t  hdl;
	} entry_t;

	typedef enum logic [2:0] {
		OP_ADD          = 3'd0,
		OP_TRUNC_PREFIX = 3'd1,
		OP_TRUNC_SUFFIX = 3'd2,
		OP_SET_SNAP     = 3'd3,
		OP_GET          = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ORDER    = 3'd1,
		ST_OLDER    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SRCH,
		S_CMP,
		S_FETCH,
		S_EXEC,
		S_RESP
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic srch_rd;
		logic srch_upd;
		logic fetch_rd;
		logic exec;
		logic resp;
	} oclt_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_search;
		logic srch_done;
		logic need_fetch;
		logic out_free;
	} oclt_sts_t;

	// Ring slot of the entry at offset off from the oldest one (off up to CAPACITY)
	function automatic ptr_t ring_pos(ptr_t head, cnt_t off);
		sum_t sum;
		sum = sum_t'(head) + sum_t'(off);
		if (sum >= sum_t'(CAPACITY)) begin
			sum = sum - sum_t'(CAPACITY);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/oclt_ctrl.sv
// Sequencing state machine: capture, binary search, fetch, execute, respond.
`default_nettype none

module oclt_ctrl import oclt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire oclt_sts_t sts,
	output oclt_cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				state_nxt = sts.need_search ? S_SRCH : S_EXEC;
			end
			S_SRCH: begin
				if (sts.srch_done) begin
					state_nxt = sts.need_fetch ? S_FETCH : S_EXEC;
				end else begin
					state_nxt = S_CMP;
				end
			end
			S_CMP:   state_nxt = S_SRCH;
			S_FETCH: state_nxt = S_EXEC;
			S_EXEC:  state_nxt = S_RESP;
			S_RESP: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_DECIDE: ;
			S_SRCH:  cmd.srch_rd  = !sts.srch_done;
			S_CMP:   cmd.srch_upd = 1'b1;
			S_FETCH: cmd.fetch_rd = 1'b1;
			S_EXEC:  cmd.exec     = 1'b1;
			S_RESP:  cmd.resp     = sts.out_free;
			default: ;
		endcase
	end

	// A taken word blocks the input until its result is out
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting a word");

	// Every search read is followed by its compare
	a_read_then_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_rd |=> cmd.srch_upd)
		else $error("search read not followed by compare");

	// At most one command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one command in a cycle");

endmodule

`default_nettype wire

>>> design/oclt_dpath.sv
// Datapath: entry memory, ring pointers, search bounds, snapshot and result registers.
`default_nettype none

module oclt_dpath import oclt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire oclt_cmd_t cmd,
	output oclt_sts_t      sts,
	input  wire logic [2:0] op,
	input  wire idx_t      log_index,
	input  wire term_t     log_term,
	input  wire hdl_t      entry_handle,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic [2:0]     status,
	output idx_t           found_index,
	output term_t          found_term,
	output hdl_t           found_handle,
	output idx_t           last_index,
	output term_t          last_term,
	output hdl_t           last_handle,
	output cnt_t           entry_count
);

	entry_t  mem [CAPACITY];

	op_t     op_q;
	idx_t    key_q;
	term_t   term_q;
	hdl_t    hdl_q;
	ptr_t    head_q;
	cnt_t    count_q;
	cnt_t    lo_q;
	cnt_t    hi_q;
	entry_t  tail_q;
	entry_t  snap_q;
	entry_t  rd_q;
	status_t status_q;
	entry_t  found_q;
	logic    out_valid_q;
	entry_t  out_found_q;
	entry_t  out_last_q;
	logic [2:0] out_status_q;
	cnt_t    out_count_q;

	sum_t    mid_sum;
	cnt_t    mid;
	ptr_t    rd_addr;
	ptr_t    wr_addr;
	entry_t  new_entry;
	logic    pred;
	logic    add_order;
	logic    add_full;
	logic    mem_we;
	logic    snap_older;
	logic    out_free;

	// Search midpoint and addresses
	assign mid_sum   = sum_t'(lo_q) + sum_t'(hi_q);
	assign mid       = mid_sum[CNT_W:1];
	assign rd_addr   = cmd.srch_rd ? ring_pos(head_q, mid) : ring_pos(head_q, lo_q - cnt_t'(1));
	assign wr_addr   = ring_pos(head_q, count_q);
	assign new_entry = '{idx: key_q, term: term_q, hdl: hdl_q};

	// Prefix truncation counts strictly smaller indexes, the others count at-or-below
	assign pred = (op_q == OP_TRUNC_PREFIX) ? (rd_q.idx < key_q) : (rd_q.idx <= key_q);

	assign add_order  = (count_q != '0) && (tail_q.idx >= key_q);
	assign add_full   = (count_q == cnt_t'(CAPACITY));
	assign mem_we     = cmd.exec && (op_q == OP_ADD) && !add_order && !add_full;
	assign snap_older = (term_q < snap_q.term) || ((term_q == snap_q.term) && (key_q < snap_q.idx));
	assign out_free   = !out_valid_q || !out_stall;

	// Status to controller
	always_comb begin
		sts.need_search = (op_q inside {OP_TRUNC_PREFIX, OP_TRUNC_SUFFIX}) ||
			((op_q == OP_GET) && (count_q != '0));
		sts.srch_done   = (lo_q == hi_q);
		sts.need_fetch  = (op_q inside {OP_GET, OP_TRUNC_SUFFIX}) && (lo_q != '0);
		sts.out_free    = out_free;
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= new_entry;
		end
		if (cmd.srch_rd || cmd.fetch_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(op);
			key_q  <= log_index;
			term_q <= log_term;
			hdl_q  <= entry_handle;
		end
	end

	// Ring pointers, search bounds and snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			snap_q  <= '0;
		end else begin
			if (cmd.capture) begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			if (cmd.srch_upd) begin
				if (pred) begin
					lo_q <= mid + cnt_t'(1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.exec) begin
				case (op_q)
					OP_ADD: begin
						if (mem_we) count_q <= count_q + cnt_t'(1);
					end
					OP_TRUNC_PREFIX: begin
						count_q <= count_q - lo_q;
						head_q  <= (count_q == lo_q) ? '0 : ring_pos(head_q, lo_q);
					end
					OP_TRUNC_SUFFIX: begin
						count_q <= lo_q;
						if (lo_q == '0) head_q <= '0;
					end
					OP_SET_SNAP: begin
						if (!snap_older) snap_q <= new_entry;
					end
					default: ;
				endcase
			end
		end
	end

	// Newest entry copy
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tail_q <= new_entry;
		end else if (cmd.exec && (op_q == OP_TRUNC_SUFFIX) && (lo_q != '0)) begin
			tail_q <= rd_q;
		end
	end

	// Operation result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= ST_OK;
			found_q  <= '0;
			case (op_q)
				OP_ADD: begin
					if (add_order) begin
						status_q <= ST_ORDER;
					end else if (add_full) begin
						status_q <= ST_FULL;
					end
				end
				OP_SET_SNAP: begin
					if (snap_older) status_q <= ST_OLDER;
				end
				OP_GET: begin
					if (count_q == '0) begin
						if (key_q < snap_q.idx) begin
							status_q <= ST_NOTFOUND;
						end else begin
							found_q <= snap_q;
						end
					end else if (lo_q == '0) begin
						status_q <= ST_NOTFOUND;
					end else begin
						found_q <= rd_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_last_q   <= (count_q != '0) ? tail_q : snap_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found_index  = out_found_q.idx;
	assign found_term   = out_found_q.term;
	assign found_handle = out_found_q.hdl;
	assign last_index   = out_last_q.idx;
	assign last_term    = out_last_q.term;
	assign last_handle  = out_last_q.hdl;
	assign entry_count  = out_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("entry count above capacity");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0))
		else $error("empty table with nonzero head");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_upd |-> ((lo_q < hi_q) && (hi_q <= count_q)))
		else $error("search bounds out of order");

endmodule

`default_nettype wire

>>> design/ordered_config_log_table_top.sv
// Top level of the ordered configuration log table.
// Add, set snapshot, other codes and get on an empty table run without a search.
// Truncations and get: a binary search of up to ceil(log2(n+1)) steps for n entries held,
// then a fetch when an entry is needed; each search step takes one registered memory read and one compare.
// The result word sits in an output register, so a new word is taken while it waits.
// Reset (arst_n low) empties the table and zeroes the snapshot; no clearing pass.
`default_nettype none

module ordered_config_log_table_top import oclt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] op,
	input  wire idx_t       log_index,
	input  wire term_t      log_term,
	input  wire hdl_t       entry_handle,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output idx_t            found_index,
	output term_t           found_term,
	output hdl_t            found_handle,
	output idx_t            last_index,
	output term_t           last_term,
	output hdl_t            last_handle,
	output cnt_t            entry_count
);

	oclt_cmd_t cmd;
	oclt_sts_t sts;

	oclt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	oclt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.log_index    (log_index),
		.log_term     (log_term),
		.entry_handle (entry_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_index  (found_index),
		.found_term   (found_term),
		.found_handle (found_handle),
		.last_index   (last_index),
		.last_term    (last_term),
		.last_handle  (last_handle),
		.entry_count  (entry_count)
	);

endmodule

`default_nettype wire

>>> test/tb_ordered_config_log_table_top.sv
// Testbench for the ordered configuration log table: directed, backpressure and random words.
`timescale 1ns / 1ps

module tb_ordered_config_log_table_top;
	import oclt_pkg::*;

	// Result of one word as the table should report it
	typedef struct packed {
		status_t st;
		entry_t  found;
		entry_t  last;
		cnt_t    cnt;
	} log_result_t;

	localparam idx_t       IDX_MAX        = '1;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam int         DRAIN_LIMIT    = 5000;
	localparam int         TAIL_CYCLES    = 40;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [2:0] op           = 3'd0;
	idx_t       log_index    = '0;
	term_t      log_term     = '0;
	hdl_t       entry_handle = '0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [2:0] status;
	idx_t       found_index;
	term_t      found_term;
	hdl_t       found_handle;
	idx_t       last_index;
	term_t      last_term;
	hdl_t       last_handle;
	cnt_t       entry_count;

	ordered_config_log_table_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.log_index    (log_index),
		.log_term     (log_term),
		.entry_handle (entry_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_index  (found_index),
		.found_term   (found_term),
		.found_handle (found_handle),
		.last_index   (last_index),
		.last_term    (last_term),
		.last_handle  (last_handle),
		.entry_count  (entry_count)
	);

	// Clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the ring table and the snapshot
	entry_t      ring_mem [CAPACITY];
	int unsigned ring_head = 0;
	int unsigned ring_used = 0;
	entry_t      snap_ent  = '0;

	log_result_t pending_results [$];
	int          fail_count     = 0;
	int          words_sent     = 0;
	int          words_checked  = 0;
	int          stalled_inputs = 0;
	int          status_seen [0:7];

	// Idling and hold-off knobs, set at falling edges; the hold-off count runs down at rising edges
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_cycles    = 0;

	// Generator view of the table, refreshed at falling edges
	int unsigned gen_used  = 0;
	idx_t        gen_first = '0;
	idx_t        gen_last  = '0;
	idx_t        gen_pick  = '0;
	entry_t      gen_snap  = '0;
	idx_t        add_floor = '0;

	function automatic int unsigned slot_of(int unsigned i);
		return (ring_head + i) % CAPACITY;
	endfunction

	// Count live entries at or below key, or strictly below it
	function automatic int unsigned entries_upto(idx_t key, bit strict);
		int unsigned n;
		n = 0;
		while (n < ring_used &&
		       (strict ? ring_mem[slot_of(n)].idx < key : ring_mem[slot_of(n)].idx <= key))
			n++;
		return n;
	endfunction

	// Apply one word to the shadow state and return the result it must produce
	function automatic log_result_t next_log_result(logic [2:0] code, idx_t key, term_t t,
	                                               hdl_t h);
		log_result_t r;
		int unsigned n;
		r = '0;
		r.st = ST_OK;
		case (code)
			OP_ADD: begin
				if (ring_used > 0 && ring_mem[slot_of(ring_used - 1)].idx >= key) begin
					r.st = ST_ORDER;
				end else if (ring_used >= CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					ring_mem[slot_of(ring_used)] = '{idx: key, term: t, hdl: h};
					ring_used++;
				end
			end
			OP_TRUNC_PREFIX: begin
				n = entries_upto(key, 1'b1);
				ring_head = slot_of(n);
				ring_used -= n;
				if (ring_used == 0) begin
					ring_head = 0;
				end
			end
			OP_TRUNC_SUFFIX: begin
				ring_used = entries_upto(key, 1'b0);
				if (ring_used == 0) begin
					ring_head = 0;
				end
			end
			OP_SET_SNAP: begin
				if (t < snap_ent.term || (t == snap_ent.term && key < snap_ent.idx)) begin
					r.st = ST_OLDER;
				end else begin
					snap_ent = '{idx: key, term: t, hdl: h};
				end
			end
			OP_GET: begin
				if (ring_used == 0) begin
					if (key < snap_ent.idx) begin
						r.st = ST_NOTFOUND;
					end else begin
						r.found = snap_ent;
					end
				end else begin
					n = entries_upto(key, 1'b0);
					if (n == 0) begin
						r.st = ST_NOTFOUND;
					end else begin
						r.found = ring_mem[slot_of(n - 1)];
					end
				end
			end
			default: ;
		endcase
		r.last = (ring_used > 0) ? ring_mem[slot_of(ring_used - 1)] : snap_ent;
		r.cnt = cnt_t'(ring_used);
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Check the result word first, then predict the input word taken at this edge
	always @(posedge clk) begin : result_check
		log_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result word with no word outstanding");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 64'(want.st), 64'(status));
					check_field("found_index", 64'(want.found.idx), 64'(found_index));
					check_field("found_term", 64'(want.found.term), 64'(found_term));
					check_field("found_handle", 64'(want.found.hdl), 64'(found_handle));
					check_field("last_index", 64'(want.last.idx), 64'(last_index));
					check_field("last_term", 64'(want.last.term), 64'(last_term));
					check_field("last_handle", 64'(want.last.hdl), 64'(last_handle));
					check_field("entry_count", 64'(want.cnt), 64'(entry_count));
					status_seen[want.st]++;
					words_checked++;
				end
			end
			if (in_valid && in_stall) begin
				stalled_inputs++;
			end
			if (in_valid && !in_stall) begin
				pending_results.insert(pending_results.size(),
				                       next_log_result(op, log_index, log_term,
				                                       entry_handle));
			end
		end
	end

	// Refresh the generator view away from the rising edge
	always @(negedge clk) begin
		gen_used  = ring_used;
		gen_first = (ring_used > 0) ? ring_mem[slot_of(0)].idx : snap_ent.idx;
		gen_last  = (ring_used > 0) ? ring_mem[slot_of(ring_used - 1)].idx : snap_ent.idx;
		gen_pick  = (ring_used > 0) ? ring_mem[slot_of($urandom_range(ring_used - 1))].idx
		                            : snap_ent.idx;
		gen_snap  = snap_ent;
	end

	// Receiver: hold off while a hold is pending, else stall at random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Offer one word, idling first at random, and return at the edge that takes it
	task automatic send_word(logic [2:0] code, idx_t key, term_t t, hdl_t h);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= code;
		log_index    <= key;
		log_term     <= t;
		entry_handle <= h;
		do begin
			@(posedge clk);
		end while (in_stall);
		words_sent++;
	endtask

	// Drop valid, change the idling mix at a falling edge, resume at a rising edge
	task automatic set_idling(int src_pct, int sink_pct);
		in_valid <= 1'b0;
		@(negedge clk);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		@(posedge clk);
	endtask

	task automatic hold_receiver(int cycles);
		in_valid <= 1'b0;
		@(negedge clk);
		hold_cycles = cycles;
		@(posedge clk);
	endtask

	function automatic idx_t rand_idx();
		return idx_t'({$urandom, $urandom});
	endfunction

	// Key near a live entry, within the held range, at an extreme, or anywhere
	function automatic idx_t pick_key();
		logic [63:0] span;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return gen_pick + idx_t'($urandom_range(2)) - idx_t'(1);
			5, 6, 7: begin
				span = {1'b0, gen_last - gen_first} + 64'd3;
				return gen_first - idx_t'(1) + idx_t'({$urandom, $urandom} % span);
			end
			8: return $urandom_range(1) ? IDX_MAX : '0;
			default: return rand_idx();
		endcase
	endfunction

	// Extremes of every field and each special case
	task automatic test_directed();
		logic [2:0] code;
		set_idling(0, 0);
		send_word(OP_GET, '0, '0, '0);
		send_word(OP_GET, IDX_MAX, '0, '0);
		send_word(OP_SET_SNAP, 63'd100, 32'd5, 32'hFFFF_FFFF);
		send_word(OP_GET, 63'd99, '0, '0);
		send_word(OP_GET, 63'd100, '0, '0);
		send_word(OP_SET_SNAP, 63'd200, 32'd4, 32'h1234_5678);
		send_word(OP_SET_SNAP, 63'd99, 32'd5, 32'h1234_5678);
		send_word(OP_SET_SNAP, 63'd100, 32'd5, 32'h0);
		send_word(OP_ADD, '0, 32'hFFFF_FFFF, 32'h0);
		send_word(OP_ADD, '0, 32'd1, 32'd1);
		send_word(OP_ADD, 63'd10, 32'h0, 32'hFFFF_FFFF);
		send_word(OP_ADD, 63'd9, 32'd2, 32'd2);
		send_word(OP_ADD, IDX_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_GET, 63'd5, '0, '0);
		send_word(OP_GET, IDX_MAX - 1, '0, '0);
		send_word(OP_GET, IDX_MAX, '0, '0);
		send_word(OP_TRUNC_SUFFIX, 63'd10, '0, '0);
		send_word(OP_TRUNC_PREFIX, '0, '0, '0);
		send_word(OP_TRUNC_PREFIX, 63'd10, '0, '0);
		send_word(OP_TRUNC_SUFFIX, IDX_MAX, '0, '0);
		send_word(OP_TRUNC_PREFIX, IDX_MAX, '0, '0);
		send_word(OP_GET, 63'd50, '0, '0);
		send_word(OP_ADD, 63'd3, 32'd6, 32'hA5A5_5A5A);
		send_word(OP_GET, 63'd2, '0, '0);
		send_word(OP_TRUNC_SUFFIX, '0, '0, '0);
		// spare codes change nothing
		for (code = OP_SPARE_FIRST; code != OP_SPARE_FIRST - 3'd1; code++) begin
			send_word(code, rand_idx(), $urandom, $urandom);
			if (code == OP_SPARE_LAST) begin
				break;
			end
		end
	endtask

	// Fill the table to capacity behind a long receiver hold-off, then wrap the ring
	task automatic test_backpressure_full();
		idx_t base;
		int   i;
		base = IDX_MAX - 63'hFFF;
		set_idling(0, 0);
		send_word(OP_TRUNC_PREFIX, IDX_MAX, '0, '0);
		hold_receiver(400);
		for (i = 0; i < CAPACITY; i++) begin
			send_word(OP_ADD, base + idx_t'(3 * i), $urandom, $urandom);
		end
		send_word(OP_ADD, base, $urandom, $urandom);
		send_word(OP_ADD, base + 63'd1000, $urandom, $urandom);
		send_word(OP_GET, base + 63'd5, '0, '0);
		send_word(OP_GET, IDX_MAX, '0, '0);
		send_word(OP_GET, base - 63'd1, '0, '0);
		send_word(OP_TRUNC_PREFIX, base + 63'd30, '0, '0);
		for (i = 0; i < 16; i++) begin
			send_word(OP_ADD, base + idx_t'(3 * CAPACITY + 2 * i), $urandom, $urandom);
		end
		send_word(OP_GET, base + idx_t'(3 * CAPACITY + 7), '0, '0);
		send_word(OP_TRUNC_SUFFIX, base + idx_t'(3 * CAPACITY + 11), '0, '0);
		send_word(OP_GET, IDX_MAX, '0, '0);
		send_word(OP_TRUNC_PREFIX, IDX_MAX, '0, '0);
	endtask

	// Mostly ordered adds with gets, truncations and snapshots; some noise
	task automatic test_random_traffic(int words, int src_pct, int sink_pct);
		int    r;
		idx_t  key;
		term_t t;
		set_idling(src_pct, sink_pct);
		send_word(OP_TRUNC_PREFIX, IDX_MAX, '0, '0);
		add_floor = idx_t'($urandom);
		repeat (words) begin
			r = $urandom_range(99);
			if (r < 40) begin
				key = (gen_used > 0 && gen_last > add_floor) ? gen_last : add_floor;
				if (key > (IDX_MAX >> 1)) begin
					// restart low before indexes run out
					add_floor = rand_idx() >> $urandom_range(2, 62);
					send_word(OP_TRUNC_PREFIX, IDX_MAX, '0, '0);
				end else begin
					key += ($urandom_range(9) == 0) ? idx_t'($urandom) + idx_t'(1)
					                                : idx_t'($urandom_range(1, 4));
					add_floor = key;
					send_word(OP_ADD, key, $urandom, $urandom);
				end
			end else if (r < 45) begin
				send_word(OP_ADD, pick_key(), $urandom, $urandom);
			end else if (r < 65) begin
				send_word(OP_GET, pick_key(), $urandom, $urandom);
			end else if (r < 73) begin
				send_word(OP_TRUNC_PREFIX, pick_key(), $urandom, $urandom);
			end else if (r < 80) begin
				send_word(OP_TRUNC_SUFFIX, pick_key(), $urandom, $urandom);
			end else if (r < 88) begin
				if ($urandom_range(9) < 7) begin
					t = gen_snap.term + term_t'($urandom_range(1));
					send_word(OP_SET_SNAP, pick_key(), t, $urandom);
				end else begin
					send_word(OP_SET_SNAP, rand_idx(), $urandom, $urandom);
				end
			end else if (r < 91) begin
				add_floor = rand_idx() >> $urandom_range(2, 62);
				send_word(OP_TRUNC_PREFIX, IDX_MAX, $urandom, $urandom);
			end else if (r < 93) begin
				send_word(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rand_idx(),
				          $urandom, $urandom);
			end else begin
				send_word(OP_GET, gen_pick, $urandom, $urandom);
			end
		end
	endtask

	// Wait for every outstanding result, then idle on for strays
	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result words never arrived", pending_results.size());
			fail_count++;
		end
	endtask

	initial begin
		foreach (status_seen[i]) begin
			status_seen[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure_full();
		test_random_traffic(700, 11, 79);
		test_random_traffic(700, 79, 11);
		test_random_traffic(700, 0, 0);
		drain_results();
		$display("Sent %0d words, checked %0d results; input held back for %0d cycles.",
		         words_sent, words_checked, stalled_inputs);
		$display("Status mix: ok %0d, out of order %0d, older snapshot %0d, not found %0d, full %0d.",
		         status_seen[ST_OK], status_seen[ST_ORDER], status_seen[ST_OLDER],
		         status_seen[ST_NOTFOUND], status_seen[ST_FULL]);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
